// ----- hdl/alab_pkg.sv -----
// Shared types and constants for the ambient light auto brightness block.
`timescale 1ns / 1ps

package alab_pkg;

    // Fixed field widths.
    localparam int ADC_BITS = 12;
    localparam int LVL_W    = 8;
    localparam int CFG_W    = 16;

    // Brightness mapping constants.
    localparam logic [ADC_BITS-1:0] AVG_FLOOR  = 12'd3000;
    localparam logic [ADC_BITS-1:0] AVG_KNEE   = 12'd3100;
    localparam logic [LVL_W-1:0]    MAP_SCALE  = 8'd155;
    localparam logic [LVL_W-1:0]    MAP_OFFSET = 8'd100;

    // Division by 995 as a multiply by a rounded-up reciprocal and a shift.
    // Exact for every dividend below 166317, which covers the mapped range.
    localparam int              P1_W        = 20;
    localparam int              RECIP_W     = 18;
    localparam int              P2_W        = P1_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_995 = 18'd134893;
    localparam int              RECIP_SHIFT = 27;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MIN_BRIGHT = 2'd0,
        CFG_MAX_BRIGHT = 2'd1,
        CFG_SMP_INT    = 2'd2,
        CFG_CALC_INT   = 2'd3
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick;
        logic div_step;
        logic mul1;
        logic mul2;
        logic map;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic calc_fire;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/alab_datapath.sv -----
// Datapath: interval counters, accumulator, serial divider, level mapping and output word.
`timescale 1ns / 1ps

module alab_datapath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  alab_pkg::t_cmd                  i_cmd,
    output alab_pkg::t_status               o_status,
    input  logic                            i_cfg_we,
    input  alab_pkg::t_cfg_idx              i_cfg_index,
    input  logic [alab_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [alab_pkg::ADC_BITS-1:0]   i_light_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [alab_pkg::LVL_W-1:0]      o_brightness,
    output logic [alab_pkg::ADC_BITS-1:0]   o_light_average,
    output logic                            o_updated
);
    import alab_pkg::*;

    localparam int SUM_W = ADC_BITS + COUNT_BITS;
    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Configuration registers.
    logic [LVL_W-1:0]      r_min_bright;
    logic [LVL_W-1:0]      r_max_bright;
    logic [CFG_W-1:0]      r_smp_int;
    logic [CFG_W-1:0]      r_calc_int;

    // Tick state.
    logic [COUNT_BITS-1:0] r_smp_elapsed;
    logic [COUNT_BITS-1:0] r_calc_elapsed;
    logic [SUM_W-1:0]      r_sum;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [LVL_W-1:0]      r_level;
    logic [ADC_BITS-1:0]   r_avg_hold;

    // Divider and mapping pipeline.
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_divisor;
    logic [ADC_BITS-1:0]   r_quo;
    logic [ADC_BITS-1:0]   r_avg;
    logic                  r_neg;
    logic [P1_W-1:0]       r_prod1;
    logic [P2_W-1:0]       r_prod2;

    // Output word.
    logic                  r_out_valid;
    logic [LVL_W-1:0]      r_out_lvl;
    logic [ADC_BITS-1:0]   r_out_avg;
    logic                  r_out_upd;

    logic [COUNT_BITS-1:0] n_smp_elapsed;
    logic [COUNT_BITS-1:0] n_calc_elapsed;
    logic                  smp_fire;
    logic                  calc_fire;
    logic [SUM_W-1:0]      n_sum;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS:0]   div_trial;
    logic [COUNT_BITS:0]   div_diff;
    logic                  div_geq;
    logic [ADC_BITS-1:0]   avg_q;
    logic [ADC_BITS-1:0]   dmag;
    logic [LVL_W-1:0]      map_q;
    logic [LVL_W:0]        map_m;
    logic [LVL_W-1:0]      n_level;

    // Saturating interval counters and the sample and calculation events.
    always_comb begin
        n_smp_elapsed  = (r_smp_elapsed == CNT_MAX) ? r_smp_elapsed : r_smp_elapsed + 1'b1;
        n_calc_elapsed = (r_calc_elapsed == CNT_MAX) ? r_calc_elapsed : r_calc_elapsed + 1'b1;
        smp_fire  = CMP_W'(n_smp_elapsed) >= CMP_W'(r_smp_int);
        calc_fire = CMP_W'(n_calc_elapsed) >= CMP_W'(r_calc_int);
    end

    // Accumulate the sample on a sample event unless the count is full.
    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (smp_fire && (r_cnt != CNT_MAX)) begin
            n_sum = r_sum + SUM_W'(i_light_sample);
            n_cnt = r_cnt + 1'b1;
        end
    end

    // One restoring division step per cycle while div_step is set.
    always_comb begin
        div_trial = {r_rem, r_quo[ADC_BITS-1]};
        div_geq   = div_trial >= {1'b0, r_divisor};
        div_diff  = div_trial - {1'b0, r_divisor};
    end

    // Magnitude of the distance from the knee, and the final level.
    always_comb begin
        avg_q = (r_divisor == '0) ? '0 : r_quo;
        dmag  = (avg_q >= AVG_KNEE) ? (avg_q - AVG_KNEE) : (AVG_KNEE - avg_q);
        map_q = r_prod2[RECIP_SHIFT +: LVL_W];
        map_m = r_neg ? ({1'b0, MAP_OFFSET} - {1'b0, map_q})
                      : ({1'b0, MAP_OFFSET} + {1'b0, map_q});
        if (r_avg < AVG_FLOOR) begin
            n_level = '0;
        end else if (map_m < {1'b0, r_min_bright}) begin
            n_level = r_min_bright;
        end else if (map_m > {1'b0, r_max_bright}) begin
            n_level = r_max_bright;
        end else begin
            n_level = map_m[LVL_W-1:0];
        end
    end

    assign o_status.calc_fire = calc_fire;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bright <= '0;
            r_max_bright <= '1;
            r_smp_int    <= 16'd100;
            r_calc_int   <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_BRIGHT: r_min_bright <= i_cfg_data[LVL_W-1:0];
                CFG_MAX_BRIGHT: r_max_bright <= i_cfg_data[LVL_W-1:0];
                CFG_SMP_INT:    r_smp_int    <= i_cfg_data;
                CFG_CALC_INT:   r_calc_int   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Tick state, level and held average.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_elapsed  <= '0;
            r_calc_elapsed <= '0;
            r_sum          <= '0;
            r_cnt          <= '0;
            r_level        <= '0;
            r_avg_hold     <= '0;
        end else begin
            if (i_cmd.tick) begin
                r_smp_elapsed  <= smp_fire ? '0 : n_smp_elapsed;
                r_calc_elapsed <= calc_fire ? '0 : n_calc_elapsed;
                r_sum          <= calc_fire ? '0 : n_sum;
                r_cnt          <= calc_fire ? '0 : n_cnt;
            end
            if (i_cmd.map) begin
                r_level    <= n_level;
                r_avg_hold <= r_avg;
            end
        end
    end

    // Divider and mapping pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick && calc_fire) begin
            r_rem     <= n_sum[SUM_W-1:ADC_BITS];
            r_quo     <= n_sum[ADC_BITS-1:0];
            r_divisor <= n_cnt;
        end else if (i_cmd.div_step) begin
            r_rem <= div_geq ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
            r_quo <= {r_quo[ADC_BITS-2:0], div_geq};
        end
        if (i_cmd.mul1) begin
            r_avg   <= avg_q;
            r_neg   <= avg_q < AVG_KNEE;
            r_prod1 <= P1_W'(dmag) * P1_W'(MAP_SCALE);
        end
        if (i_cmd.mul2) begin
            r_prod2 <= P2_W'(r_prod1) * P2_W'(RECIP_995);
        end
    end

    // Output word: a plain tick reports the held values, a calculation the new ones.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.tick && !calc_fire) || i_cmd.map) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick && !calc_fire) begin
            r_out_lvl <= r_level;
            r_out_avg <= r_avg_hold;
            r_out_upd <= 1'b0;
        end else if (i_cmd.map) begin
            r_out_lvl <= n_level;
            r_out_avg <= r_avg;
            r_out_upd <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_brightness    = r_out_lvl;
    assign o_light_average = r_out_avg;
    assign o_updated       = r_out_upd;

endmodule

// ----- hdl/alab_ctrl.sv -----
// Controller: accepts ticks and sequences the divider and the mapping steps.
`timescale 1ns / 1ps

module alab_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  alab_pkg::t_status i_status,
    output alab_pkg::t_cmd    o_cmd
);
    import alab_pkg::*;

    localparam int DIV_CNT_W = $clog2(ADC_BITS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ADC_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_MAP
    } t_state;

    t_state               r_state;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 accept;

    // A word is taken only when idle and the output register can take a result.
    assign o_in_stall = !(i_rst_n && (r_state == S_IDLE) && i_status.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    assign o_cmd.tick     = accept;
    assign o_cmd.div_step = r_state == S_DIV;
    assign o_cmd.mul1     = r_state == S_MUL1;
    assign o_cmd.mul2     = r_state == S_MUL2;
    assign o_cmd.map      = r_state == S_MAP;

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_div_cnt <= '0;
                    if (accept && i_status.calc_fire) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_LAST) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_MAP;
                S_MAP:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/ambient_light_auto_brightness_top.sv -----
// Top level of the ambient light auto brightness block.
`timescale 1ns / 1ps

// Each input word is one time tick carrying a 12-bit light reading on
// i_light_sample, moved with i_in_valid / o_in_stall. Every tick yields
// exactly one output word (brightness, last average, updated flag) on
// o_out_valid / i_out_stall. On sample-interval ticks the reading joins a
// running sum and count; on calculation-interval ticks the average is formed
// and mapped to a brightness level, clamped unless the average is below the floor.
// An ordinary tick's word is registered at acceptance and shows in the cycle after. A
// calculation tick runs a 12-step serial divider and three mapping steps
// (two multiplies and a clamp) before its word appears; no new word is
// taken during that time. Throughput is one tick per cycle between
// calculations while the output register is not held by i_out_stall.
// The output register holds a word while i_out_stall is high, and a new tick
// is taken in the cycle the held word leaves.
// Synchronous reset (i_rst_n low) clears counters, sum, level and average,
// and restores the register defaults: min 0, max 255, sample interval 100,
// calculation interval 1000. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_data while the block is idle.
module ambient_light_auto_brightness_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [alab_pkg::ADC_BITS-1:0]   i_light_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [alab_pkg::LVL_W-1:0]      o_brightness,
    output logic [alab_pkg::ADC_BITS-1:0]   o_light_average,
    output logic                            o_updated,
    input  logic                            i_cfg_we,
    input  alab_pkg::t_cfg_idx              i_cfg_index,
    input  logic [alab_pkg::CFG_W-1:0]      i_cfg_data
);
    import alab_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    alab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage.
    alab_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_light_sample  (i_light_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_brightness    (o_brightness),
        .o_light_average (o_light_average),
        .o_updated       (o_updated)
    );

endmodule

// ----- hdl/alab_checker.sv -----
// Port-level checks for the ambient light auto brightness block, bound to the top level.
`timescale 1ns / 1ps

module alab_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [alab_pkg::LVL_W-1:0]    o_brightness,
    input logic [alab_pkg::ADC_BITS-1:0] o_light_average
);
    import alab_pkg::*;

    // A stalled output word stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // No tick is taken while a finished word is stuck in the output register.
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("tick accepted while output register is full");

    // A held average below the floor always goes with a dark display.
    a_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_light_average < AVG_FLOOR) |-> o_brightness == '0)
        else $error("nonzero brightness for an average below the floor");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

endmodule

bind ambient_light_auto_brightness_top alab_checker u_alab_checker (.*);

// ----- sim/ambient_light_auto_brightness_top_tb.sv -----
// Self-checking testbench for the ambient light auto brightness block.
`timescale 1ns / 1ps

module ambient_light_auto_brightness_top_tb;

    import alab_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PRINT_CAP = 40;

    // Mapping constants for the brightness curve.
    localparam int DARK_LIMIT = 3000;
    localparam int KNEE = 3100;
    localparam int SLOPE_NUM = 155;
    localparam int SLOPE_DEN = 995;
    localparam int BASE_LEVEL = 100;

    // Light scenes used by the random traffic.
    localparam int SCENE_ANY = 0;
    localparam int SCENE_BRIGHT = 1;
    localparam int SCENE_NEAR_KNEE = 2;

    typedef struct {
        logic [LVL_W-1:0]    level;
        logic [ADC_BITS-1:0] average;
        logic                updated;
    } t_bright_word;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [ADC_BITS-1:0] i_light_sample = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [LVL_W-1:0]    o_brightness;
    logic [ADC_BITS-1:0] o_light_average;
    logic                o_updated;
    logic                i_cfg_we = 1'b0;
    t_cfg_idx            i_cfg_index = CFG_MIN_BRIGHT;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    // Register copies, at their reset values.
    logic [LVL_W-1:0] cfg_min = 8'd0;
    logic [LVL_W-1:0] cfg_max = 8'd255;
    logic [CFG_W-1:0] cfg_smp_int = 16'd100;
    logic [CFG_W-1:0] cfg_calc_int = 16'd1000;

    // Running state of the brightness predictor.
    logic [CFG_W-1:0]          smp_elapsed = '0;
    logic [CFG_W-1:0]          calc_elapsed = '0;
    logic [ADC_BITS+CFG_W-1:0] light_sum = '0;
    logic [CFG_W-1:0]          light_count = '0;
    logic [LVL_W-1:0]          cur_level = 8'd0;
    logic [ADC_BITS-1:0]       held_average = '0;

    t_bright_word bright_q[$];
    int mismatches = 0;
    int sender_gap_pct = 0;
    int receiver_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    ambient_light_auto_brightness_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_light_sample  (i_light_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_brightness    (o_brightness),
        .o_light_average (o_light_average),
        .o_updated       (o_updated),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Average to brightness; dark scenes bypass the clamp entirely.
    function automatic logic [LVL_W-1:0] map_average(input logic [ADC_BITS-1:0] avg);
        int lvl;
        if (int'(avg) < DARK_LIMIT) return 8'd0;
        lvl = (int'(avg) - KNEE) * SLOPE_NUM / SLOPE_DEN + BASE_LEVEL;
        if (lvl < int'(cfg_min)) begin
            lvl = int'(cfg_min);
        end else if (lvl > int'(cfg_max)) begin
            lvl = int'(cfg_max);
        end
        return lvl[LVL_W-1:0];
    endfunction

    // Advance the predictor by one tick and queue the word it should produce.
    task automatic advance_light_tick(input logic [ADC_BITS-1:0] sample);
        t_bright_word w;
        logic [ADC_BITS+CFG_W-1:0] quotient;
        w.updated = 1'b0;
        if (smp_elapsed != '1) smp_elapsed++;
        if (calc_elapsed != '1) calc_elapsed++;
        if (smp_elapsed >= cfg_smp_int) begin
            if (light_count != '1) begin
                light_sum += sample;
                light_count++;
            end
            smp_elapsed = '0;
        end
        if (calc_elapsed >= cfg_calc_int) begin
            quotient = (light_count == 0) ? '0 : light_sum / light_count;
            held_average = quotient[ADC_BITS-1:0];
            cur_level = map_average(held_average);
            light_sum = '0;
            light_count = '0;
            calc_elapsed = '0;
            w.updated = 1'b1;
        end
        w.level = cur_level;
        w.average = held_average;
        bright_q.push_back(w);
    endtask

    // Offer one tick word, with random gaps ahead of it, until it is taken.
    task automatic send_tick(input logic [ADC_BITS-1:0] sample);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_light_sample <= sample;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_light_tick(sample);
    endtask

    // Stop offering and wait until every expected word has come out.
    task automatic wait_for_quiet();
        i_in_valid <= 1'b0;
        while (bright_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_BRIGHT: cfg_min = data[LVL_W-1:0];
            CFG_MAX_BRIGHT: cfg_max = data[LVL_W-1:0];
            CFG_SMP_INT:    cfg_smp_int = data;
            CFG_CALC_INT:   cfg_calc_int = data;
            default: ;
        endcase
    endtask

    // Writes all four registers; only called while the block is idle.
    task automatic set_config(input logic [LVL_W-1:0] lo, input logic [LVL_W-1:0] hi,
                              input logic [CFG_W-1:0] smp, input logic [CFG_W-1:0] calc);
        write_reg(CFG_MIN_BRIGHT, {8'd0, lo});
        write_reg(CFG_MAX_BRIGHT, {8'd0, hi});
        write_reg(CFG_SMP_INT, smp);
        write_reg(CFG_CALC_INT, calc);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [LVL_W-1:0] pick_bound();
        int r;
        r = $urandom_range(99);
        if (r < 20) return 8'd0;
        if (r < 40) return 8'd255;
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic logic [CFG_W-1:0] pick_interval(input int top);
        int r;
        r = $urandom_range(99);
        if (r < 8) return 16'd0;
        if (r < 14) return 16'hFFFF;
        if (r < 18) return 16'($urandom_range(65535, 1));
        return 16'($urandom_range(top, 1));
    endfunction

    function automatic logic [ADC_BITS-1:0] pick_light(input int scene, input int base);
        int v;
        case (scene)
            SCENE_BRIGHT:    v = $urandom_range(4095, 2900);
            SCENE_NEAR_KNEE: v = base + $urandom_range(120, 0) - 60;
            default:         v = $urandom_range(4095, 0);
        endcase
        return v[ADC_BITS-1:0];
    endfunction

    // Ticks under the power-on register values.
    task automatic test_reset_defaults();
        send_tick(12'hFFF);
        send_tick(12'h000);
        wait_for_quiet();
    endtask

    // Average equals the sample when both intervals are one tick.
    task automatic test_mapping();
        set_config(8'd0, 8'd255, 16'd1, 16'd1);
        send_tick(12'd0);
        send_tick(12'd2999);
        send_tick(12'd3000);
        send_tick(12'd3099);
        send_tick(12'd3100);
        send_tick(12'd4095);
        send_tick(12'hAAA);
        send_tick(12'h555);
        send_tick(12'd3600);
        wait_for_quiet();
        // Lower bound above upper bound: low clamp wins, dark stays zero.
        set_config(8'd200, 8'd100, 16'd1, 16'd1);
        send_tick(12'd3000);
        send_tick(12'd4095);
        send_tick(12'd2999);
        wait_for_quiet();
    endtask

    task automatic test_window_cases();
        // Calculation before any sample lands gives an empty window.
        set_config(8'd0, 8'd255, 16'd3, 16'd2);
        repeat (4) send_tick(12'd3500);
        wait_for_quiet();
        // Zero intervals fire on every tick.
        set_config(8'd7, 8'd200, 16'd0, 16'd0);
        send_tick(12'd3050);
        send_tick(12'd100);
        wait_for_quiet();
        // A new lower bound only shows at the next calculation.
        set_config(8'd0, 8'd255, 16'd1, 16'd3);
        repeat (3) send_tick(12'd3000);
        wait_for_quiet();
        set_config(8'd90, 8'd255, 16'd1, 16'd3);
        repeat (3) send_tick(12'd3000);
        wait_for_quiet();
    endtask

    // Segments of ticks, each under a fresh random register setting and scene.
    task automatic test_random_traffic(input int n_ticks);
        int sent;
        int seg;
        int scene;
        int base;
        sent = 0;
        while (sent < n_ticks) begin
            set_config(pick_bound(), pick_bound(), pick_interval(6), pick_interval(40));
            seg = $urandom_range(120, 30);
            scene = $urandom_range(2, 0);
            base = $urandom_range(3160, 2960);
            repeat (seg) send_tick(pick_light(scene, base));
            sent += seg;
            wait_for_quiet();
        end
    endtask

    // Long receiver hold-off while ticks keep coming, then a full pause and more ticks with the usual gaps.
    task automatic test_backpressure();
        int saved_gap;
        saved_gap = sender_gap_pct;
        sender_gap_pct = 0;
        set_config(8'd10, 8'd240, 16'd2, 16'd5);
        hold_request = HOLD_OFF_CYCLES;
        repeat (60) send_tick(pick_light(SCENE_BRIGHT, 0));
        wait_for_quiet();
        sender_gap_pct = saved_gap;
        repeat (30) send_tick(pick_light(SCENE_ANY, 0));
        wait_for_quiet();
    endtask

    // Check each output word and drive the receiver stall.
    always @(posedge i_clk) begin : result_check
        t_bright_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (bright_q.size() == 0) begin
                report_mismatch("output word with nothing expected");
            end else begin
                want = bright_q.pop_front();
                if (o_brightness !== want.level || o_light_average !== want.average ||
                    o_updated !== want.updated) begin
                    report_mismatch($sformatf(
                        "brightness %0d average %0d updated %b, expected %0d %0d %b",
                        o_brightness, o_light_average, o_updated,
                        want.level, want.average, want.updated));
                end
            end
        end
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Ends the run when neither side moves a word for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("ambient_light_auto_brightness_top regression: fail");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_gap_pct = 26;
        receiver_stall_pct = 76;
        test_reset_defaults();
        test_mapping();
        test_window_cases();
        test_random_traffic(480);
        sender_gap_pct = 76;
        receiver_stall_pct = 26;
        test_random_traffic(480);
        test_backpressure();
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        test_random_traffic(480);
        if (bright_q.size() != 0) begin
            report_mismatch("expected words left over");
        end
        if (mismatches == 0) begin
            $display("ambient_light_auto_brightness_top regression: pass");
        end else begin
            $display("ambient_light_auto_brightness_top regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/alab_pkg.sv
hdl/alab_datapath.sv
hdl/alab_ctrl.sv
hdl/ambient_light_auto_brightness_top.sv
hdl/alab_checker.sv
sim/ambient_light_auto_brightness_top_tb.sv
